FILE: rtl/aarm_pkg.sv
// Shared widths, types and arithmetic helpers for the axis-angle rotation matrix block.
package aarm_pkg;

	// Fixed-point format of every field.
	localparam int FRAC_BITS = 16;
	localparam int DW        = 18;
	localparam int CFG_W     = 8;

	localparam longint ONE     = longint'(1) << FRAC_BITS;
	localparam longint HALF    = longint'(1) << (FRAC_BITS - 1);
	localparam longint ONE_SQ  = longint'(1) << (2 * FRAC_BITS);
	localparam longint FMAX    = (longint'(1) << (DW - 1)) - 1;
	localparam longint LIM     = (ONE < FMAX) ? ONE : FMAX;

	// Stream widths, padded to whole bytes.
	localparam int IN_FIELDS  = 4;
	localparam int OUT_FIELDS = 9;
	localparam int IN_TDATA_W  = ((IN_FIELDS * DW + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_FIELDS * DW + 7) / 8) * 8;

	// Product and rounding widths.
	localparam int PROD_W = 2 * DW;
	localparam int Q_W    = PROD_W + 1 - FRAC_BITS;
	localparam int T_W    = ((FRAC_BITS + 2 > DW) ? FRAC_BITS + 2 : DW) + 1;
	localparam int TQ_W   = T_W + Q_W;
	localparam int TR_W   = TQ_W + 1 - FRAC_BITS;

	// Square root of 1 - c*c.
	localparam int RAD_W  = 2 * FRAC_BITS + 2;
	localparam int D_W    = ((PROD_W > RAD_W) ? PROD_W : RAD_W) + 1;
	localparam int SQ_DIG = RAD_W / 2;
	localparam int S_W    = FRAC_BITS + 1;
	localparam int REM_W  = S_W + 3;
	localparam int SQ_PER = 2;
	localparam int SQ_STG = (SQ_DIG + SQ_PER - 1) / SQ_PER;

	// Sine products and matrix entry sums.
	localparam int SA_W = S_W + 1 + DW;
	localparam int SR_W = SA_W + 1 - FRAC_BITS;
	localparam int E_W  = ((TR_W > SR_W) ? ((TR_W > DW) ? TR_W : DW)
		: ((SR_W > DW) ? SR_W : DW)) + 2;

	// Order of the quadratic axis terms.
	localparam int Q_XX = 0;
	localparam int Q_YY = 1;
	localparam int Q_ZZ = 2;
	localparam int Q_XY = 3;
	localparam int Q_XZ = 4;
	localparam int Q_YZ = 5;
	localparam int NQ   = 6;

	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	// Item data that travels alongside the square root.
	typedef struct packed {
		logic                      deg;
		logic [2:0][DW-1:0]        axis;
		logic [DW-1:0]             c;
		logic [T_W-1:0]            t;
		logic [NQ-1:0][Q_W-1:0]    q;
	} side_t;

	// One finished matrix.
	typedef struct packed {
		logic                          deg;
		logic [OUT_FIELDS-1:0][DW-1:0] rot;
	} res_t;

	// Round to nearest, ties toward plus infinity, for a full axis product.
	function automatic logic signed [Q_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] sum;
		sum = (PROD_W + 1)'(p) + $signed((PROD_W + 1)'(HALF));
		return sum[PROD_W:FRAC_BITS];
	endfunction

	function automatic logic signed [TR_W-1:0] rnd_tq(input logic signed [TQ_W-1:0] p);
		logic signed [TQ_W:0] sum;
		sum = (TQ_W + 1)'(p) + $signed((TQ_W + 1)'(HALF));
		return sum[TQ_W:FRAC_BITS];
	endfunction

	function automatic logic signed [SR_W-1:0] rnd_sa(input logic signed [SA_W-1:0] p);
		logic signed [SA_W:0] sum;
		sum = (SA_W + 1)'(p) + $signed((SA_W + 1)'(HALF));
		return sum[SA_W:FRAC_BITS];
	endfunction

	// Clamp an entry sum to plus or minus the limit.
	function automatic logic [DW-1:0] sat_entry(input logic signed [E_W-1:0] e);
		logic signed [E_W-1:0] lim;
		lim = $signed(E_W'(LIM));
		if (e > lim) begin
			return DW'(lim);
		end else if (e < -lim) begin
			return DW'(-lim);
		end
		return e[DW-1:0];
	endfunction

endpackage

FILE: rtl/aarm_front.sv
// Front stages: axis products, tolerance check, 1 - c and the radicand 1 - c*c.
module aarm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              ce,
	input  logic                              in_valid,
	input  logic signed [aarm_pkg::DW-1:0]    axis_x,
	input  logic signed [aarm_pkg::DW-1:0]    axis_y,
	input  logic signed [aarm_pkg::DW-1:0]    axis_z,
	input  logic signed [aarm_pkg::DW-1:0]    cosine,
	input  logic [aarm_pkg::CFG_W-1:0]        zero_tolerance,
	output logic                              out_valid,
	output logic [aarm_pkg::RAD_W-1:0]        out_rad,
	output aarm_pkg::side_t                   out_side
);
	import aarm_pkg::*;

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
		return a[DW-1] ? (~a + DW'(1)) : a;
	endfunction

	logic                         vld_s1, vld_s2;
	logic signed [PROD_W-1:0]     prod_s1 [NQ];
	logic signed [PROD_W-1:0]     cc_s1;
	logic signed [T_W-1:0]        t_s1;
	logic [2:0][DW-1:0]           axis_s1;
	logic [DW-1:0]                c_s1;
	logic                         deg_s1;
	logic [RAD_W-1:0]             rad_s2;
	side_t                        side_s2;
	logic signed [D_W-1:0]        diff;
	logic [DW-1:0]                tol_ext;

	assign tol_ext = DW'(zero_tolerance);

	// Valid bits advance with the pipeline enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: the six axis products, c squared, t = 1 - c and the tolerance check.
	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1[Q_XX] <= axis_x * axis_x;
			prod_s1[Q_YY] <= axis_y * axis_y;
			prod_s1[Q_ZZ] <= axis_z * axis_z;
			prod_s1[Q_XY] <= axis_x * axis_y;
			prod_s1[Q_XZ] <= axis_x * axis_z;
			prod_s1[Q_YZ] <= axis_y * axis_z;
			cc_s1         <= cosine * cosine;
			t_s1          <= $signed(T_W'(ONE)) - T_W'(cosine);
			axis_s1[AX_X] <= axis_x;
			axis_s1[AX_Y] <= axis_y;
			axis_s1[AX_Z] <= axis_z;
			c_s1          <= cosine;
			deg_s1        <= (mag(axis_x) < tol_ext) && (mag(axis_y) < tol_ext)
				&& (mag(axis_z) < tol_ext);
		end
	end

	// Radicand 1 - c*c, taken as zero when negative.
	assign diff = $signed(D_W'(ONE_SQ)) - D_W'(cc_s1);

	// Stage 2: round the axis products and clamp the radicand.
	always_ff @(posedge clk) begin
		if (ce) begin
			rad_s2       <= diff[D_W-1] ? '0 : diff[RAD_W-1:0];
			side_s2.deg  <= deg_s1;
			side_s2.axis <= axis_s1;
			side_s2.c    <= c_s1;
			side_s2.t    <= t_s1;
			for (int i = 0; i < NQ; i++) begin
				side_s2.q[i] <= rnd_prod(prod_s1[i]);
			end
		end
	end

	assign out_valid = vld_s2;
	assign out_rad   = rad_s2;
	assign out_side  = side_s2;

endmodule

FILE: rtl/aarm_sqrt.sv
// Pipelined digit-by-digit square root with round to nearest; carries item data alongside.
module aarm_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ce,
	input  logic                          in_valid,
	input  logic [aarm_pkg::RAD_W-1:0]    in_rad,
	input  aarm_pkg::side_t               in_side,
	output logic                          out_valid,
	output logic [aarm_pkg::S_W-1:0]      out_root,
	output aarm_pkg::side_t               out_side
);
	import aarm_pkg::*;

	logic                 vld_s   [SQ_STG];
	logic [RAD_W-1:0]     rad_s   [SQ_STG];
	logic [REM_W-1:0]     rem_s   [SQ_STG];
	logic [S_W-1:0]       root_s  [SQ_STG];
	side_t                side_s  [SQ_STG];

	logic [RAD_W-1:0]     rad_n   [SQ_STG];
	logic [REM_W-1:0]     rem_n   [SQ_STG];
	logic [S_W-1:0]       root_n  [SQ_STG];

	logic                 vld_out_s;
	logic [S_W-1:0]       sine_s;
	side_t                side_out_s;

	// Each stage resolves SQ_PER root digits from the previous stage's remainder.
	always_comb begin
		logic [RAD_W-1:0] rd;
		logic [REM_W-1:0] rm;
		logic [REM_W-1:0] rem2;
		logic [REM_W-1:0] trial;
		logic [S_W-1:0]   rt;
		int               d;
		for (int j = 0; j < SQ_STG; j++) begin
			if (j == 0) begin
				rd = in_rad;
				rm = '0;
				rt = '0;
			end else begin
				rd = rad_s[j-1];
				rm = rem_s[j-1];
				rt = root_s[j-1];
			end
			for (int k = 0; k < SQ_PER; k++) begin
				d = j * SQ_PER + k;
				if (d < SQ_DIG) begin
					rem2  = {rm[REM_W-3:0], rd[RAD_W-1-2*d -: 2]};
					trial = {1'b0, rt, 2'b01};
					if (rem2 >= trial) begin
						rm = rem2 - trial;
						rt = {rt[S_W-2:0], 1'b1};
					end else begin
						rm = rem2;
						rt = {rt[S_W-2:0], 1'b0};
					end
				end
			end
			rad_n[j]  = rd;
			rem_n[j]  = rm;
			root_n[j] = rt;
		end
	end

	// Valid bits of the digit stages and the rounding stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SQ_STG; j++) begin
				vld_s[j] <= 1'b0;
			end
			vld_out_s <= 1'b0;
		end else if (ce) begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < SQ_STG; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
			vld_out_s <= vld_s[SQ_STG-1];
		end
	end

	// Digit stage payload.
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s[0] <= in_side;
			for (int j = 1; j < SQ_STG; j++) begin
				side_s[j] <= side_s[j-1];
			end
			for (int j = 0; j < SQ_STG; j++) begin
				rad_s[j]  <= rad_n[j];
				rem_s[j]  <= rem_n[j];
				root_s[j] <= root_n[j];
			end
		end
	end

	// Round to nearest: add one when the remainder exceeds the floor root.
	always_ff @(posedge clk) begin
		if (ce) begin
			sine_s     <= root_s[SQ_STG-1]
				+ S_W'(rem_s[SQ_STG-1] > REM_W'(root_s[SQ_STG-1]));
			side_out_s <= side_s[SQ_STG-1];
		end
	end

	assign out_valid = vld_out_s;
	assign out_root  = sine_s;
	assign out_side  = side_out_s;

endmodule

FILE: rtl/aarm_mat.sv
// Matrix assembly: t and sine products, rounding, entry sums and saturation.
module aarm_mat (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ce,
	input  logic                          in_valid,
	input  logic [aarm_pkg::S_W-1:0]      in_sine,
	input  aarm_pkg::side_t               in_side,
	output logic                          out_valid,
	output aarm_pkg::res_t                out_res
);
	import aarm_pkg::*;

	logic                      vld_s1, vld_s2, vld_s3;
	logic signed [TQ_W-1:0]    tq_s1  [NQ];
	logic signed [SA_W-1:0]    sa_s1  [3];
	logic [DW-1:0]             c_s1;
	logic                      deg_s1;
	logic signed [TR_W-1:0]    tr_s2  [NQ];
	logic signed [SR_W-1:0]    sr_s2  [3];
	logic signed [DW-1:0]      c_s2;
	logic                      deg_s2;
	res_t                      res_s3;
	logic signed [E_W-1:0]     ent    [OUT_FIELDS];
	logic signed [E_W-1:0]     ce_w;
	logic signed [S_W:0]       sine_sx;

	assign sine_sx = {1'b0, in_sine};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: t times each quadratic term, sine times each axis component.
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < NQ; i++) begin
				tq_s1[i] <= $signed(in_side.t) * $signed(in_side.q[i]);
			end
			for (int i = 0; i < 3; i++) begin
				sa_s1[i] <= sine_sx * $signed(in_side.axis[i]);
			end
			c_s1   <= in_side.c;
			deg_s1 <= in_side.deg;
		end
	end

	// Stage 2: round all products back to the Q1.16 grid.
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < NQ; i++) begin
				tr_s2[i] <= rnd_tq(tq_s1[i]);
			end
			for (int i = 0; i < 3; i++) begin
				sr_s2[i] <= rnd_sa(sa_s1[i]);
			end
			c_s2   <= c_s1;
			deg_s2 <= deg_s1;
		end
	end

	// Rodrigues entries, row major.
	assign ce_w   = E_W'(c_s2);
	assign ent[0] = E_W'(tr_s2[Q_XX]) + ce_w;
	assign ent[1] = E_W'(tr_s2[Q_XY]) - E_W'(sr_s2[AX_Z]);
	assign ent[2] = E_W'(tr_s2[Q_XZ]) + E_W'(sr_s2[AX_Y]);
	assign ent[3] = E_W'(tr_s2[Q_XY]) + E_W'(sr_s2[AX_Z]);
	assign ent[4] = E_W'(tr_s2[Q_YY]) + ce_w;
	assign ent[5] = E_W'(tr_s2[Q_YZ]) - E_W'(sr_s2[AX_X]);
	assign ent[6] = E_W'(tr_s2[Q_XZ]) - E_W'(sr_s2[AX_Y]);
	assign ent[7] = E_W'(tr_s2[Q_YZ]) + E_W'(sr_s2[AX_X]);
	assign ent[8] = E_W'(tr_s2[Q_ZZ]) + ce_w;

	// Stage 3: saturate, or substitute the identity for a degenerate axis.
	always_ff @(posedge clk) begin
		if (ce) begin
			res_s3.deg <= deg_s2;
			for (int i = 0; i < OUT_FIELDS; i++) begin
				if (deg_s2) begin
					res_s3.rot[i] <= (i % 4 == 0) ? DW'(LIM) : '0;
				end else begin
					res_s3.rot[i] <= sat_entry(ent[i]);
				end
			end
		end
	end

	assign out_valid = vld_s3;
	assign out_res   = res_s3;

endmodule

FILE: rtl/aarm_skid.sv
// Output register with one skid entry; stalls the pipeline only when the skid is full.
module aarm_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  aarm_pkg::res_t    in_res,
	output logic              pipe_en,
	output logic              out_valid,
	input  logic              out_ready,
	output aarm_pkg::res_t    out_res
);
	import aarm_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	res_t    out_res_q;
	res_t    skid_res_q;
	logic    out_free;

	assign pipe_en  = !skid_valid_q;
	assign out_free = !out_valid_q || out_ready;

	// Occupancy of the output and skid slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves: skid drains first, then the pipeline end.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_res_q <= skid_valid_q ? skid_res_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_res_q <= in_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

FILE: rtl/axis_angle_rotation_matrix_top.sv
// Top level: axis and cosine in, Rodrigues rotation matrix out, fully pipelined.
//
//  Channel   Direction  Transaction contents
//  s_axis    in         tdata: axis_x, axis_y, axis_z, cosine (18 bits each)
//  m_axis    out        tdata: rot_00 .. rot_22 (18 bits each); tuser: degenerate_axis
//  cfg       in         cfg_wr_data: zero_tolerance (8 bits), written when cfg_wr_en
//
// One transaction is accepted per cycle while the skid entry is free.
// The depth is set by the square root, which resolves two root digits per stage.
// Reset clears all valid bits and sets zero_tolerance to 1.
// A stalled output holds its transaction; one skid entry takes the next finished
// matrix, and once it is full the whole pipeline holds together.
module axis_angle_rotation_matrix_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// axis_x, axis_y, axis_z, cosine
	input  logic [aarm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22, zero pad
	output logic [aarm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// degenerate_axis
	output logic [0:0]                            m_axis_tuser,
	input  logic                                  cfg_wr_en,
	input  logic [aarm_pkg::CFG_W-1:0]            cfg_wr_data
);
	import aarm_pkg::*;

	logic [CFG_W-1:0]   zero_tolerance_q;
	logic               pipe_en;
	logic               in_valid;
	logic               front_valid;
	logic [RAD_W-1:0]   front_rad;
	side_t              front_side;
	logic               sqrt_valid;
	logic [S_W-1:0]     sqrt_sine;
	side_t              sqrt_side;
	logic               mat_valid;
	res_t               mat_res;
	res_t               out_res;

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_tolerance_q <= CFG_W'(1);
		end else if (cfg_wr_en) begin
			zero_tolerance_q <= cfg_wr_data;
		end
	end

	assign s_axis_tready = pipe_en;
	assign in_valid      = s_axis_tvalid && pipe_en;

	aarm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.ce             (pipe_en),
		.in_valid       (in_valid),
		.axis_x         ($signed(s_axis_tdata[0*DW +: DW])),
		.axis_y         ($signed(s_axis_tdata[1*DW +: DW])),
		.axis_z         ($signed(s_axis_tdata[2*DW +: DW])),
		.cosine         ($signed(s_axis_tdata[3*DW +: DW])),
		.zero_tolerance (zero_tolerance_q),
		.out_valid      (front_valid),
		.out_rad        (front_rad),
		.out_side       (front_side)
	);

	aarm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (pipe_en),
		.in_valid  (front_valid),
		.in_rad    (front_rad),
		.in_side   (front_side),
		.out_valid (sqrt_valid),
		.out_root  (sqrt_sine),
		.out_side  (sqrt_side)
	);

	aarm_mat u_mat (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (pipe_en),
		.in_valid  (sqrt_valid),
		.in_sine   (sqrt_sine),
		.in_side   (sqrt_side),
		.out_valid (mat_valid),
		.out_res   (mat_res)
	);

	aarm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mat_valid),
		.in_res    (mat_res),
		.pipe_en   (pipe_en),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Pack the nine entries, lowest first, zero padded to whole bytes.
	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < OUT_FIELDS; i++) begin
			m_axis_tdata[i*DW +: DW] = out_res.rot[i];
		end
	end

	assign m_axis_tuser = out_res.deg;

endmodule

FILE: tb/axis_angle_rotation_matrix_top_tb.sv
// Self-checking testbench for the axis-angle rotation matrix block.
module axis_angle_rotation_matrix_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import aarm_pkg::*;

	// Input to output latency of the pipeline, in cycles.
	localparam int LATENCY = 16;

	// One axis and cosine transaction, as signed fixed point.
	typedef struct {
		logic signed [DW-1:0] ax;
		logic signed [DW-1:0] ay;
		logic signed [DW-1:0] az;
		logic signed [DW-1:0] cosine;
	} axis_item_t;

	// One rotation matrix, row major, with the degenerate axis flag.
	typedef struct {
		logic [DW-1:0] rot [9];
		logic          degenerate;
	} matrix_t;

	// Predicts each matrix from the accepted axis and compares what comes out.
	class rotation_scoreboard;
		matrix_t     expected_q[$];
		int unsigned error_count;

		function new();
			error_count = 0;
		endfunction

		// Round to nearest at the fraction point, ties toward plus infinity.
		static function longint round_q(longint p);
			return (p + HALF) >>> FRAC_BITS;
		endfunction

		static function longint t_prod(longint t, longint a, longint b);
			return round_q(t * round_q(a * b));
		endfunction

		static function logic [DW-1:0] clamp_entry(longint e);
			if (e > LIM) begin
				e = LIM;
			end else if (e < -LIM) begin
				e = -LIM;
			end
			return e[DW-1:0];
		endfunction

		static function logic is_near_zero(longint a, logic [7:0] tol);
			longint mag;
			mag = (a < 0) ? -a : a;
			return mag < longint'(tol);
		endfunction

		// Rodrigues matrix for one axis and cosine at the given tolerance.
		static function matrix_t predict_rotation(axis_item_t it, logic [7:0] tol);
			matrix_t m;
			longint  x, y, z, c, t, v, r, cand, s;
			longint  sx, sy, sz, txy, txz, tyz;
			longint  e [9];
			int      b;
			x = longint'(it.ax);
			y = longint'(it.ay);
			z = longint'(it.az);
			c = longint'(it.cosine);
			if (is_near_zero(x, tol) && is_near_zero(y, tol) && is_near_zero(z, tol)) begin
				for (int i = 0; i < 9; i++) begin
					m.rot[i] = (i % 4 == 0) ? clamp_entry(LIM) : '0;
				end
				m.degenerate = 1'b1;
				return m;
			end
			t = ONE - c;
			v = ONE * ONE - c * c;
			if (v < 0) begin
				v = 0;
			end
			// Integer square root, one bit at a time, then round to nearest.
			r = 0;
			for (b = 17; b >= 0; b--) begin
				cand = r | (longint'(1) << b);
				if (cand * cand <= v) begin
					r = cand;
				end
			end
			if (v > r * r + r) begin
				r++;
			end
			s = r;
			sx = round_q(s * x);
			sy = round_q(s * y);
			sz = round_q(s * z);
			txy = t_prod(t, x, y);
			txz = t_prod(t, x, z);
			tyz = t_prod(t, y, z);
			e[0] = t_prod(t, x, x) + c;
			e[1] = txy - sz;
			e[2] = txz + sy;
			e[3] = txy + sz;
			e[4] = t_prod(t, y, y) + c;
			e[5] = tyz - sx;
			e[6] = txz - sy;
			e[7] = tyz + sx;
			e[8] = t_prod(t, z, z) + c;
			for (int i = 0; i < 9; i++) begin
				m.rot[i] = clamp_entry(e[i]);
			end
			m.degenerate = 1'b0;
			return m;
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			error_count++;
		endtask

		function void note_axis(axis_item_t it, logic [7:0] tol);
			expected_q.push_back(predict_rotation(it, tol));
		endfunction

		task check_matrix(logic [OUT_TDATA_W-1:0] data, logic degenerate);
			matrix_t exp_m;
			logic [DW-1:0] got;
			if (expected_q.size() == 0) begin
				report("output transaction with no matrix expected");
				return;
			end
			exp_m = expected_q.pop_front();
			for (int i = 0; i < 9; i++) begin
				got = data[i*DW +: DW];
				if (got !== exp_m.rot[i]) begin
					report($sformatf("rot_%0d%0d is %0d, expected %0d", i / 3, i % 3,
						$signed(got), $signed(exp_m.rot[i])));
				end
			end
			if (degenerate !== exp_m.degenerate) begin
				report($sformatf("degenerate_axis is %b, expected %b", degenerate,
					exp_m.degenerate));
			end
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]       cfg_wr_data = '0;

	// Tolerance the block holds, as the predictor sees it.
	logic [7:0]         tolerance = 8'd1;
	int                 idle_pct = 0;
	int                 stall_pct = 0;
	rotation_scoreboard sb = new();

	axis_angle_rotation_matrix_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Inputs change only at rising edges, so the values at the falling edge
	// are the ones that the next rising edge accepts.
	always @(negedge clk) begin
		axis_item_t it;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				it.ax     = s_axis_tdata[0*DW +: DW];
				it.ay     = s_axis_tdata[1*DW +: DW];
				it.az     = s_axis_tdata[2*DW +: DW];
				it.cosine = s_axis_tdata[3*DW +: DW];
				sb.note_axis(it, tolerance);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_matrix(m_axis_tdata, m_axis_tuser[0]);
			end
		end
	end

	// Output side back-pressure in random bursts.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	function automatic axis_item_t make_axis(int x, int y, int z, int c);
		axis_item_t it;
		it.ax     = DW'(x);
		it.ay     = DW'(y);
		it.az     = DW'(z);
		it.cosine = DW'(c);
		return it;
	endfunction

	// Mostly unit axes with an in-range cosine, plus near-zero axes,
	// raw bit patterns and axes along the coordinate directions.
	function automatic axis_item_t random_axis();
		axis_item_t it;
		int         kind;
		real        rx, ry, rz, norm;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			rx = real'(int'($urandom_range(0, 2000)) - 1000);
			ry = real'(int'($urandom_range(0, 2000)) - 1000);
			rz = real'(int'($urandom_range(0, 2000)) - 1000);
			norm = $sqrt(rx * rx + ry * ry + rz * rz);
			if (norm < 1.0) begin
				rx = 1.0;
				norm = 1.0;
			end
			it = make_axis($rtoi(rx / norm * 65536.0), $rtoi(ry / norm * 65536.0),
				$rtoi(rz / norm * 65536.0), int'($urandom_range(0, 131072)) - 65536);
		end else if (kind < 75) begin
			it = make_axis(int'($urandom_range(0, 600)) - 300,
				int'($urandom_range(0, 600)) - 300,
				int'($urandom_range(0, 600)) - 300,
				int'($urandom_range(0, 131072)) - 65536);
		end else if (kind < 90) begin
			it.ax     = DW'($urandom());
			it.ay     = DW'($urandom());
			it.az     = DW'($urandom());
			it.cosine = DW'($urandom());
		end else begin
			it = make_axis(0, 0, 0, int'($urandom_range(0, 131072)) - 65536);
			case ($urandom_range(0, 2))
				0: it.ax = DW'($urandom_range(0, 1) ? 65536 : -65536);
				1: it.ay = DW'($urandom_range(0, 1) ? 65536 : -65536);
				default: it.az = DW'($urandom_range(0, 1) ? 65536 : -65536);
			endcase
		end
		return it;
	endfunction

	// Offer one transaction and hold it until the block takes it.
	task automatic send_axis(input axis_item_t it);
		logic accepted;
		if ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'({it.cosine, it.az, it.ay, it.ax});
		accepted = 1'b0;
		while (!accepted) begin
			@(negedge clk);
			accepted = s_axis_tready;
			@(posedge clk);
		end
	endtask

	// Wait for every expected matrix, then let the pipeline settle.
	task automatic drain_pipeline();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [7:0] value);
		drain_pipeline();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tolerance = value;
	endtask

	// Axes just inside and just outside the tolerance, then random traffic.
	task automatic run_phase(input int n_items, input int i_pct, input int s_pct);
		int tol;
		idle_pct  = i_pct;
		stall_pct = s_pct;
		tol = int'(tolerance);
		send_axis(make_axis(tol - 1, -(tol - 1), tol - 1, 0));
		send_axis(make_axis(tol, 0, 0, 32768));
		send_axis(make_axis(0, 0, -tol, -65536));
		repeat (n_items) send_axis(random_axis());
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases at the reset tolerance of one.
		idle_pct  = 20;
		stall_pct = 20;
		send_axis(make_axis(0, 0, 0, 65536));
		send_axis(make_axis(0, 0, 0, -131072));
		send_axis(make_axis(65536, 0, 0, 0));
		send_axis(make_axis(-65536, 0, 0, -65536));
		send_axis(make_axis(0, 65536, 0, 65536));
		send_axis(make_axis(0, 0, 65536, 46341));
		send_axis(make_axis(37837, 37837, 37837, -32768));
		send_axis(make_axis(-37837, -37837, -37837, 32768));
		send_axis(make_axis(131071, 131071, 131071, 131071));
		send_axis(make_axis(-131072, -131072, -131072, -131072));
		send_axis(make_axis(0, 0, 1, 0));
		send_axis(make_axis(0, -1, 0, 0));
		send_axis(make_axis(46341, -46341, 0, 1));
		send_axis(make_axis(0, 65536, 0, 65537));
		send_axis(make_axis(65536, 65536, 65536, -65536));
		send_axis(make_axis(-131072, 0, 131071, 0));
		run_phase(150, 20, 20);

		// Tolerance sweeps, with the extremes of the register.
		set_tolerance(8'd255);
		run_phase(150, 30, 30);
		set_tolerance(8'd0);
		run_phase(150, 10, 10);
		set_tolerance(8'($urandom_range(2, 254)));
		run_phase(150, 25, 5);
		set_tolerance(8'd1);
		run_phase(150, 5, 25);

		// Last stretch runs at full rate on both sides.
		set_tolerance(8'd128);
		run_phase(200, 0, 0);

		drain_pipeline();
		if (sb.error_count == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Generous bound on the whole run.
	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
rtl/aarm_pkg.sv
rtl/aarm_front.sv
rtl/aarm_sqrt.sv
rtl/aarm_mat.sv
rtl/aarm_skid.sv
rtl/axis_angle_rotation_matrix_top.sv
tb/axis_angle_rotation_matrix_top_tb.sv
